// ----- rtl/saa_pkg.sv -----
// Package: shared types, constants and codes for the shelf atlas allocator.
package saa_pkg;

	localparam int PAGE_CAP_DEF   = 4;
	localparam int STAMP_BITS_DEF = 32;
	localparam int DIM_W          = 14;
	localparam int CNT_W          = 16;
	localparam int LIM_W          = 3;
	localparam int PG_W           = 2;
	localparam int ST_W           = 3;
	localparam int PAD            = 2;
	localparam int DIM_MAX        = 16383;
	localparam int ADDR_W         = 4;
	localparam int QDEPTH         = 2;

	localparam logic [ST_W-1:0] ST_PLACED   = 3'd0;
	localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
	localparam logic [ST_W-1:0] ST_TOOLARGE = 3'd2;
	localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd3;
	localparam logic [ST_W-1:0] ST_TOUCHED  = 3'd4;
	localparam logic [ST_W-1:0] ST_IGNORED  = 3'd5;

	localparam logic [ADDR_W-1:0] REG_WIDTH  = 4'h0;
	localparam logic [ADDR_W-1:0] REG_HEIGHT = 4'h4;
	localparam logic [ADDR_W-1:0] REG_LIMIT  = 4'h8;

	localparam logic [DIM_W-1:0] WIDTH_RST  = 14'd1024;
	localparam logic [DIM_W-1:0] HEIGHT_RST = 14'd1024;
	localparam logic [LIM_W-1:0] LIMIT_RST  = 3'd4;

	typedef struct packed {
		logic             mode;
		logic [DIM_W-1:0] rect_width;
		logic [DIM_W-1:0] rect_height;
		logic [PG_W-1:0]  touch_page;
	} req_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [PG_W-1:0]  page_sel;
		logic [DIM_W-1:0] pos_x;
		logic [DIM_W-1:0] pos_y;
		logic             opened_page;
		logic             evicted;
	} rsp_t;

	// classified command handed from front to back
	typedef struct packed {
		logic             direct;
		logic [ST_W-1:0]  status;
		logic             touch;
		logic [PG_W-1:0]  page;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
	} cmd_t;

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [LIM_W-1:0] limit;
	} cfg_t;

endpackage

// ----- rtl/shelf_atlas_allocator_lru_pages.sv -----
// Top level of the shelf atlas allocator with LRU page recycling.
// One request per start beat while busy is low; its result appears later as a one-cycle
// strobe beat that cannot be held off. Empty and too-large requests are answered from idle,
// touches go straight to the update state, and placements wait on the back end stepping one
// page record per cycle through the first-fit search and then, if no page can be opened,
// the LRU victim search.
module shelf_atlas_allocator_lru_pages #(
	parameter int PAGE_CAP   = saa_pkg::PAGE_CAP_DEF,
	parameter int STAMP_BITS = saa_pkg::STAMP_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  saa_pkg::req_t              req,
	output logic                       strobe,
	output saa_pkg::rsp_t              result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [saa_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	saa_pkg::cfg_t cfg_q;
	saa_pkg::cmd_t cmd;
	logic          cmd_valid, pop, fbusy;

	assign pready = 1'b1;
	assign busy   = fbusy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{saa_pkg::WIDTH_RST, saa_pkg::HEIGHT_RST, saa_pkg::LIMIT_RST};
		end else if (psel && penable && pwrite) begin
			unique case (paddr)
				saa_pkg::REG_WIDTH:  cfg_q.width  <= pwdata[saa_pkg::DIM_W-1:0];
				saa_pkg::REG_HEIGHT: cfg_q.height <= pwdata[saa_pkg::DIM_W-1:0];
				saa_pkg::REG_LIMIT:  cfg_q.limit  <= pwdata[saa_pkg::LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			saa_pkg::REG_WIDTH:  prdata = {18'b0, cfg_q.width};
			saa_pkg::REG_HEIGHT: prdata = {18'b0, cfg_q.height};
			saa_pkg::REG_LIMIT:  prdata = {29'b0, cfg_q.limit};
			default:             prdata = '0;
		endcase
	end

	saa_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req), .cfg(cfg_q), .pop(pop),
		.busy(fbusy), .cmd_valid(cmd_valid), .cmd(cmd)
	);

	saa_back #(.PAGE_CAP(PAGE_CAP), .STAMP_BITS(STAMP_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .cmd_valid(cmd_valid), .cmd(cmd),
		.pop(pop), .strobe(strobe), .result(result)
	);

endmodule

// ----- rtl/saa_front.sv -----
// Front: takes requests, classifies them, and pushes commands into a short queue.
module saa_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  saa_pkg::req_t   req,
	input  saa_pkg::cfg_t   cfg,
	input  logic            pop,
	output logic            busy,
	output logic            cmd_valid,
	output saa_pkg::cmd_t   cmd
);

	saa_pkg::cmd_t q_q [saa_pkg::QDEPTH];
	logic          rd_q, wr_q;
	logic [1:0]    cnt_q;
	saa_pkg::cmd_t c;
	logic          push;

	assign busy      = (cnt_q != 2'd0);
	assign push      = start && !busy;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_q[rd_q];

	always_comb begin
		c        = '0;
		c.page   = req.touch_page;
		c.w      = req.rect_width;
		c.h      = req.rect_height;
		c.touch  = req.mode;
		if (!req.mode) begin
			c.page = '0;
			if (req.rect_width == '0 || req.rect_height == '0) begin
				c.direct = 1'b1;
				c.status = saa_pkg::ST_EMPTY;
			end else if (req.rect_width > cfg.width || req.rect_height > cfg.height) begin
				c.direct = 1'b1;
				c.status = saa_pkg::ST_TOOLARGE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_q[wr_q] <= c;
	end

endmodule

// ----- rtl/saa_back.sv -----
// Back: first-fit page search, page open, LRU victim search and state update.
module saa_back #(
	parameter int PAGE_CAP   = saa_pkg::PAGE_CAP_DEF,
	parameter int STAMP_BITS = saa_pkg::STAMP_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  saa_pkg::cfg_t cfg,
	input  logic          cmd_valid,
	input  saa_pkg::cmd_t cmd,
	output logic          pop,
	output logic          strobe,
	output saa_pkg::rsp_t result
);

	localparam int PI_W = (PAGE_CAP > 1) ? $clog2(PAGE_CAP) : 1;
	localparam int OP_W = $clog2(PAGE_CAP + 1);
	localparam logic [2:0] S_IDLE = 3'd0, S_FIT = 3'd1, S_VIC = 3'd2, S_DO = 3'd3;

	logic [2:0]                 state_q;
	logic [saa_pkg::DIM_W-1:0]  cx_q [PAGE_CAP];
	logic [saa_pkg::DIM_W-1:0]  cy_q [PAGE_CAP];
	logic [saa_pkg::DIM_W-1:0]  rh_q [PAGE_CAP];
	logic [saa_pkg::CNT_W-1:0]  rc_q [PAGE_CAP];
	logic [STAMP_BITS-1:0]      ls_q [PAGE_CAP];
	logic [STAMP_BITS-1:0]      clk_q;
	logic [OP_W-1:0]            open_q;
	logic [PI_W-1:0]            p_q;
	logic [PI_W-1:0]            pg_q;
	logic                       found_q;
	logic [STAMP_BITS-1:0]      old_q;
	logic                       clr_q, opn_q, evc_q;
	saa_pkg::cmd_t              c_q;

	logic [saa_pkg::DIM_W+1:0]  x, y, rh, endy;
	logic [saa_pkg::DIM_W-1:0]  ux, uy, urh;
	logic [OP_W-1:0]            lim;
	logic [STAMP_BITS-1:0]      nstamp;
	logic [saa_pkg::DIM_W+1:0]  nx;
	logic                       tp_ok;
	logic                       last_p;

	// wrapped cursor of page p_q (or cleared page)
	always_comb begin
		ux  = clr_q ? '0 : cx_q[p_q];
		uy  = clr_q ? '0 : cy_q[p_q];
		urh = clr_q ? '0 : rh_q[p_q];
		x   = {2'b0, ux};
		y   = {2'b0, uy};
		rh  = {2'b0, urh};
		if ({2'b0, ux} + {2'b0, c_q.w} + (saa_pkg::DIM_W+2)'(saa_pkg::PAD) > {2'b0, cfg.width}) begin
			x  = '0;
			y  = {2'b0, uy} + {2'b0, urh} + (saa_pkg::DIM_W+2)'(saa_pkg::PAD);
			if (y > (saa_pkg::DIM_W+2)'(saa_pkg::DIM_MAX)) y = (saa_pkg::DIM_W+2)'(saa_pkg::DIM_MAX);
			rh = '0;
		end
		endy = y + {2'b0, c_q.h};
		nx   = x + {2'b0, c_q.w} + (saa_pkg::DIM_W+2)'(saa_pkg::PAD);
		if (nx > (saa_pkg::DIM_W+2)'(saa_pkg::DIM_MAX)) nx = (saa_pkg::DIM_W+2)'(saa_pkg::DIM_MAX);
		lim    = (int'(cfg.limit) > PAGE_CAP) ? OP_W'(PAGE_CAP) : OP_W'(cfg.limit);
		nstamp = (clk_q == '1) ? clk_q : clk_q + 1'b1;
		tp_ok  = (int'(c_q.page) < int'(open_q)) && (int'(c_q.page) < PAGE_CAP);
		last_p = (OP_W'(p_q) + 1'b1 >= open_q);
	end

	assign pop = (state_q == S_IDLE) && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			strobe  <= 1'b0;
			result  <= '0;
			open_q  <= OP_W'(1);
			clk_q   <= '0;
			c_q     <= '0;
			p_q     <= '0;
			pg_q    <= '0;
			found_q <= 1'b0;
			old_q   <= '0;
			clr_q   <= 1'b0;
			opn_q   <= 1'b0;
			evc_q   <= 1'b0;
			for (int i = 0; i < PAGE_CAP; i++) begin
				cx_q[i] <= '0; cy_q[i] <= '0; rh_q[i] <= '0; rc_q[i] <= '0; ls_q[i] <= '0;
			end
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						c_q   <= cmd;
						p_q   <= '0;
						clr_q <= 1'b0;
						opn_q <= 1'b0;
						evc_q <= 1'b0;
						found_q <= 1'b0;
						if (cmd.direct) begin
							strobe <= 1'b1;
							result <= '{cmd.status, '0, '0, '0, 1'b0, 1'b0};
						end else if (cmd.touch) begin
							state_q <= S_DO;
						end else begin
							state_q <= S_FIT;
						end
					end
				end
				S_FIT: begin
					if (endy <= {2'b0, cfg.height}) begin
						state_q <= S_DO;
					end else if (!last_p) begin
						p_q <= p_q + 1'b1;
					end else if (open_q < lim) begin
						p_q     <= PI_W'(open_q);
						open_q  <= open_q + 1'b1;
						clr_q   <= 1'b1;
						opn_q   <= 1'b1;
						state_q <= S_DO;
					end else begin
						p_q     <= '0;
						pg_q    <= '0;
						state_q <= S_VIC;
					end
				end
				S_VIC: begin
					if (rc_q[p_q] != '0 && (!found_q || ls_q[p_q] < old_q)) begin
						found_q <= 1'b1;
						old_q   <= ls_q[p_q];
						pg_q    <= p_q;
					end
					if (last_p) begin
						state_q <= S_DO;
						clr_q   <= 1'b1;
						evc_q   <= 1'b1;
						p_q     <= (rc_q[p_q] != '0 && (!found_q || ls_q[p_q] < old_q))
							? p_q : pg_q;
					end else begin
						p_q <= p_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					strobe  <= 1'b1;
					if (c_q.touch) begin
						result <= '{tp_ok ? saa_pkg::ST_TOUCHED : saa_pkg::ST_IGNORED,
							c_q.page, '0, '0, 1'b0, 1'b0};
						if (tp_ok) begin
							ls_q[PI_W'(c_q.page)] <= nstamp;
							clk_q <= nstamp;
						end
					end else begin
						cy_q[p_q] <= y[saa_pkg::DIM_W-1:0];
						if (endy > {2'b0, cfg.height}) begin
							result <= '{saa_pkg::ST_OVERFLOW, saa_pkg::PG_W'(p_q), '0, '0,
								opn_q, evc_q};
							cx_q[p_q] <= x[saa_pkg::DIM_W-1:0];
							rh_q[p_q] <= rh[saa_pkg::DIM_W-1:0];
							if (clr_q) begin
								rc_q[p_q] <= '0;
								ls_q[p_q] <= '0;
							end
						end else begin
							result <= '{saa_pkg::ST_PLACED, saa_pkg::PG_W'(p_q),
								x[saa_pkg::DIM_W-1:0], y[saa_pkg::DIM_W-1:0], opn_q, evc_q};
							cx_q[p_q] <= nx[saa_pkg::DIM_W-1:0];
							rh_q[p_q] <= ({2'b0, c_q.h} > rh) ? c_q.h : rh[saa_pkg::DIM_W-1:0];
							if (clr_q) rc_q[p_q] <= saa_pkg::CNT_W'(1);
							else if (rc_q[p_q] != '1) rc_q[p_q] <= rc_q[p_q] + 1'b1;
							ls_q[p_q] <= nstamp;
							clk_q     <= nstamp;
						end
					end
				end
			endcase
		end
	end

endmodule

// ----- rtl/saa_checker.sv -----
// Checker: port-level properties of the allocator, bound to the top level.
module saa_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          strobe,
	input saa_pkg::rsp_t result
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted beat did not raise busy");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> result.status <= saa_pkg::ST_IGNORED) else $error("bad status");

	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.status != saa_pkg::ST_PLACED |-> result.pos_x == '0 && result.pos_y == '0)
		else $error("position set on non-placed result");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !(result.opened_page && result.evicted)) else $error("opened and evicted");

endmodule

bind shelf_atlas_allocator_lru_pages saa_checker u_saa_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .strobe(strobe), .result(result)
);

// ----- bench/shelf_atlas_allocator_lru_pages_chk.sv -----
// Checker: watches request and result beats, predicts the allocator and compares.
module shelf_atlas_allocator_lru_pages_chk
	import saa_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  busy,
	input  req_t  req,
	input  logic  strobe,
	input  rsp_t  result,
	input  logic  psel,
	input  logic  penable,
	input  logic  pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	input  logic  pready,
	output int    fail_count,
	output int    pending
);
	localparam int NPG = PAGE_CAP_DEF;

	logic [DIM_W-1:0] cfg_w, cfg_h;
	logic [LIM_W-1:0] cfg_lim;
	int unsigned n_open;
	int unsigned cur_x [NPG], cur_y [NPG], row_h [NPG], n_rects [NPG];
	longint unsigned stamp [NPG];
	longint unsigned use_clk;
	rsp_t placements [$];

	function automatic int unsigned sat_dim(int unsigned v);
		return v > DIM_MAX ? DIM_MAX : v;
	endfunction

	function automatic longint unsigned bump_clock();
		if (use_clk < 64'hFFFF_FFFF) use_clk++;
		return use_clk;
	endfunction

	function automatic void clear_page(int p);
		cur_x[p] = 0; cur_y[p] = 0; row_h[p] = 0; n_rects[p] = 0; stamp[p] = 0;
	endfunction

	function automatic void row_wrap(int p, int unsigned w, output int unsigned x,
			output int unsigned y, output int unsigned rh);
		x = cur_x[p]; y = cur_y[p]; rh = row_h[p];
		if (x + w + PAD > cfg_w) begin
			x = 0; y = sat_dim(y + rh + PAD); rh = 0;
		end
	endfunction

	function automatic rsp_t allocate(req_t r);
		rsp_t o;
		int unsigned w, h, x, y, rh, lim, oldest;
		int pg;
		bit found;
		o = '0;
		w = r.rect_width; h = r.rect_height;
		if (r.mode) begin
			o.page_sel = r.touch_page;
			if (r.touch_page < n_open) begin
				stamp[r.touch_page] = bump_clock();
				o.status = ST_TOUCHED;
			end else o.status = ST_IGNORED;
		end else if (w == 0 || h == 0) o.status = ST_EMPTY;
		else if (w > cfg_w || h > cfg_h) o.status = ST_TOOLARGE;
		else begin
			lim = cfg_lim < NPG ? cfg_lim : NPG;
			found = 0; pg = 0;
			for (int p = 0; p < n_open && p < NPG; p++) begin
				row_wrap(p, w, x, y, rh);
				if (y + h <= cfg_h) begin
					found = 1; pg = p; break;
				end
			end
			if (!found) begin
				if (n_open < lim) begin
					pg = n_open; n_open++; o.opened_page = 1;
				end else begin
					for (int p = 0; p < n_open && p < NPG; p++) begin
						if (n_rects[p] == 0) continue;
						if (!found || stamp[p] < stamp[pg]) begin
							pg = p; found = 1;
						end
					end
					if (!found) pg = 0;
					o.evicted = 1;
				end
				clear_page(pg);
			end
			o.page_sel = PG_W'(pg);
			row_wrap(pg, w, x, y, rh);
			cur_x[pg] = x; cur_y[pg] = y; row_h[pg] = rh;
			if (y + h > cfg_h) o.status = ST_OVERFLOW;
			else begin
				o.status = ST_PLACED;
				o.pos_x = DIM_W'(x); o.pos_y = DIM_W'(y);
				cur_x[pg] = sat_dim(x + w + PAD);
				if (h > rh) row_h[pg] = h;
				if (n_rects[pg] < 65535) n_rects[pg]++;
				stamp[pg] = bump_clock();
			end
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w = WIDTH_RST; cfg_h = HEIGHT_RST; cfg_lim = LIMIT_RST;
			n_open = 1; use_clk = 0;
			for (int p = 0; p < NPG; p++) clear_page(p);
			placements.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (strobe) begin
				if (placements.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) $display("unexpected result beat %p", result);
				end else begin
					rsp_t e;
					e = placements.pop_front();
					if (result !== e) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %p got %p", e, result);
					end
				end
			end
			if (start && !busy) placements.insert(placements.size(), allocate(req));
			if (psel && penable && pwrite && pready) begin
				case (paddr)
					REG_WIDTH:  cfg_w = pwdata[DIM_W-1:0];
					REG_HEIGHT: cfg_h = pwdata[DIM_W-1:0];
					REG_LIMIT:  cfg_lim = pwdata[LIM_W-1:0];
					default: ;
				endcase
			end
			pending = placements.size();
		end
	end
endmodule

// ----- bench/shelf_atlas_allocator_lru_pages_tb.sv -----
// Testbench top: drives requests and register writes, gives the verdict.
module shelf_atlas_allocator_lru_pages_tb;
	import saa_pkg::*;

	logic clk = 0, arst_n = 0;
	logic start = 0, busy, strobe;
	req_t req = '0;
	rsp_t result;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0, prdata;
	logic pready;
	int fail_count, pending;

	always #10 clk = ~clk;

	shelf_atlas_allocator_lru_pages u_dut (.*);
	shelf_atlas_allocator_lru_pages_chk u_chk (.*);

	function automatic int gap_len();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) n = 0;
		return n;
	endfunction

	// start stays high through a zero gap so the next beat follows directly
	task automatic send(bit m, int unsigned w, int unsigned h, int unsigned tp);
		req_t r;
		int n;
		r.mode = m; r.rect_width = DIM_W'(w); r.rect_height = DIM_W'(h);
		r.touch_page = PG_W'(tp);
		start <= 1;
		req <= r;
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
		n = gap_len();
		if (n > 0) begin
			start <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic reg_write(logic [ADDR_W-1:0] a, int unsigned v);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		start <= 0;
		while (pending != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic set_cfg(int unsigned w, int unsigned h, int unsigned lim);
		drain();
		reg_write(REG_WIDTH, w);
		reg_write(REG_HEIGHT, h);
		reg_write(REG_LIMIT, lim);
	endtask

	task automatic random_items(int n, int unsigned maxd);
		int unsigned w, h;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 4) == 0)
				send(1, $urandom, $urandom, $urandom_range(0, 3));
			else begin
				w = $urandom_range(1, maxd); h = $urandom_range(1, maxd);
				case ($urandom_range(0, 15))
					0: w = 0;
					1: h = 0;
					2: w = $urandom_range(0, 16383);
					3: h = $urandom_range(0, 16383);
					default: ;
				endcase
				send(0, w, h, $urandom);
			end
		end
	endtask

	initial begin
		#200000000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send(0, 0, 5, 0);
		send(0, 5, 0, 0);
		send(0, 1025, 4, 0);
		send(0, 4, 16383, 0);
		send(0, 1, 1, 0);
		send(0, 1022, 100, 0);
		send(0, 1024, 1024, 0);
		send(1, 0, 0, 0);
		send(1, 0, 0, 3);
		send(0, 1024, 1024, 0);
		send(0, 1024, 1024, 0);
		send(0, 1024, 1024, 0);
		send(1, 0, 0, 2);
		send(1, 16383, 16383, 1);
		send(0, 1024, 1024, 0);
		set_cfg(8192, 8192, 1);
		send(0, 8192, 8192, 0);
		send(0, 8191, 1, 0);
		set_cfg(1, 3, 0);
		send(0, 1, 1, 0);
		send(0, 1, 3, 0);
		set_cfg(0, 0, 7);
		send(0, 1, 1, 0);
		set_cfg(16383, 16383, 2);
		send(0, 16383, 16383, 0);
		set_cfg(64, 64, 4);
		random_items(300, 40);
		set_cfg(32, 48, 2);
		random_items(250, 30);
		set_cfg(200, 100, 3);
		random_items(250, 90);
		set_cfg($urandom_range(1, 16383), $urandom_range(1, 16383), $urandom_range(0, 7));
		random_items(250, 16383);
		drain();
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

// ----- filelist.f -----
rtl/saa_pkg.sv
rtl/saa_front.sv
rtl/saa_back.sv
rtl/shelf_atlas_allocator_lru_pages.sv
rtl/saa_checker.sv
bench/shelf_atlas_allocator_lru_pages_chk.sv
bench/shelf_atlas_allocator_lru_pages_tb.sv
